@@ hw/rtl/jcp_pkg.sv @@
// Shared types and constants for the joystick calibrated position core.
package jcp_pkg;

  localparam int SAMPLE_W = 8;
  localparam int SPAN_W   = SAMPLE_W + 1;
  localparam int FS_W     = 7;
  localparam int SPLIT_W  = 9;
  localparam int NUM_W    = FS_W + SAMPLE_W;
  localparam int POS_W    = 8;
  localparam int DIR_W    = 3;
  localparam int MODE_W   = 2;
  localparam int IDX_W    = 2;
  localparam int CFG_W    = 9;
  localparam int STEP_W   = 4;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 24;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

  localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRACK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FINISH  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MEASURE = 2'd3;

  localparam logic [IDX_W-1:0] REG_FULL_SCALE = 2'd0;
  localparam logic [IDX_W-1:0] REG_DIR_THRESH = 2'd1;
  localparam logic [IDX_W-1:0] REG_SIDE_SPLIT = 2'd2;

  localparam logic [FS_W-1:0]    FULL_SCALE_RST = 7'd100;
  localparam logic [FS_W-1:0]    DIR_THRESH_RST = 7'd50;
  localparam logic [SPLIT_W-1:0] SIDE_SPLIT_RST = '0;

  localparam logic [DIR_W-1:0] DIR_MIDDLE = 3'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT   = 3'd2;
  localparam logic [DIR_W-1:0] DIR_UP     = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DOWN   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_WAIT,
    ST_DONE
  } state_t;

endpackage

@@ hw/rtl/jcp_div.sv @@
// Iterative restoring unsigned divider, one quotient bit per cycle.
module jcp_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [jcp_pkg::NUM_W-1:0]         dividend,
  input  logic [jcp_pkg::SAMPLE_W-1:0]      divisor,
  output logic                              done,
  output logic [jcp_pkg::NUM_W-1:0]         quotient
);

  logic                            busy;
  logic [jcp_pkg::STEP_W-1:0]      step;
  logic [jcp_pkg::SAMPLE_W-1:0]    rem;
  logic [jcp_pkg::SAMPLE_W-1:0]    dsr;
  logic [jcp_pkg::SAMPLE_W:0]      rem_shift;
  logic [jcp_pkg::SAMPLE_W:0]      rem_diff;
  logic                            fits;

  assign rem_shift = {rem, quotient[jcp_pkg::NUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, dsr};
  assign fits      = rem_shift >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == jcp_pkg::LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[jcp_pkg::NUM_W-2:0], fits};
      rem      <= fits ? rem_diff[jcp_pkg::SAMPLE_W-1:0] : rem_shift[jcp_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

@@ hw/rtl/joystick_calibrated_position_core.sv @@
// Top level of the joystick calibration and position scaling core.
// Each input word carries a mode and one sample per axis. Start, track and finish words
// update the calibration when accepted and produce no output. For a measure word the x
// axis and then the y axis each pass through a multiply state, a divider load state and a
// wait on the shared bit-serial divider for its 15 quotient bits, and then the done state
// moves the result word to the output register once the output is free. A new input word
// is taken once the previous measure has moved its result there. Registers are written
// through cfg_wr_en, cfg_index and cfg_data.
module joystick_calibrated_position_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [jcp_pkg::IN_W-1:0]          s_tdata,   // mode, x_sample, y_sample
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [jcp_pkg::OUT_W-1:0]         m_tdata,   // pos_x, pos_y, direction
  input  logic                              cfg_wr_en,
  input  logic [jcp_pkg::IDX_W-1:0]         cfg_index,
  input  logic [jcp_pkg::CFG_W-1:0]         cfg_data
);

  jcp_pkg::state_t state, state_next;

  logic [jcp_pkg::FS_W-1:0]      full_scale;
  logic [jcp_pkg::FS_W-1:0]      dir_threshold;
  logic [jcp_pkg::SPLIT_W-1:0]   side_split;

  logic [jcp_pkg::SAMPLE_W-1:0]  x_low, x_high, y_low, y_high, x_centre, y_centre;
  logic [jcp_pkg::SPAN_W-1:0]    x_span_lower, x_span_upper, y_span_lower, y_span_upper;

  logic [jcp_pkg::MODE_W-1:0]    in_mode;
  logic [jcp_pkg::SAMPLE_W-1:0]  in_x, in_y;
  logic                          accept;

  logic [jcp_pkg::SAMPLE_W-1:0]  x_samp, y_samp;
  logic                          axis;
  logic [jcp_pkg::NUM_W-1:0]     num;
  logic [jcp_pkg::SAMPLE_W-1:0]  span_mag;
  logic                          neg;
  logic                          span_zero;
  logic                          off_nz;
  logic [jcp_pkg::POS_W-1:0]     pos_x, pos_y;

  logic [jcp_pkg::SAMPLE_W-1:0]  cur_samp, cur_centre;
  logic [jcp_pkg::SPAN_W-1:0]    cur_lower, cur_upper, cur_span, cur_off;
  logic [jcp_pkg::SAMPLE_W-1:0]  off_mag;
  logic [jcp_pkg::NUM_W-1:0]     prod;

  logic                          div_start;
  logic                          div_done;
  logic [jcp_pkg::NUM_W-1:0]     div_q;
  logic [jcp_pkg::FS_W-1:0]      mag;
  logic [jcp_pkg::POS_W-1:0]     pos_new;

  logic                          out_free;
  logic [jcp_pkg::DIR_W-1:0]     dir_new;
  logic signed [jcp_pkg::POS_W:0] px_s, py_s, th_s;

  assign in_mode = s_tdata[1:0];
  assign in_x    = s_tdata[9:2];
  assign in_y    = s_tdata[17:10];
  assign accept  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale    <= jcp_pkg::FULL_SCALE_RST;
      dir_threshold <= jcp_pkg::DIR_THRESH_RST;
      side_split    <= jcp_pkg::SIDE_SPLIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        jcp_pkg::REG_FULL_SCALE: full_scale    <= cfg_data[jcp_pkg::FS_W-1:0];
        jcp_pkg::REG_DIR_THRESH: dir_threshold <= cfg_data[jcp_pkg::FS_W-1:0];
        jcp_pkg::REG_SIDE_SPLIT: side_split    <= cfg_data[jcp_pkg::SPLIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_low        <= '0;
      x_high       <= '0;
      y_low        <= '0;
      y_high       <= '0;
      x_centre     <= '0;
      y_centre     <= '0;
      x_span_lower <= '0;
      x_span_upper <= '0;
      y_span_lower <= '0;
      y_span_upper <= '0;
    end else if (accept) begin
      case (in_mode)
        jcp_pkg::MODE_START: begin
          x_low  <= in_x;
          x_high <= in_x;
          y_low  <= in_y;
          y_high <= in_y;
        end
        jcp_pkg::MODE_TRACK: begin
          if (in_x > x_high) x_high <= in_x;
          if (in_x < x_low)  x_low  <= in_x;
          if (in_y > y_high) y_high <= in_y;
          if (in_y < y_low)  y_low  <= in_y;
        end
        jcp_pkg::MODE_FINISH: begin
          x_centre     <= in_x;
          y_centre     <= in_y;
          x_span_lower <= {1'b0, in_x} - {1'b0, x_low};
          x_span_upper <= {1'b0, x_high} - {1'b0, in_x};
          y_span_lower <= {1'b0, in_y} - {1'b0, y_low};
          y_span_upper <= {1'b0, y_high} - {1'b0, in_y};
        end
        default: ;
      endcase
    end
  end

  // select the axis being scaled and form |full_scale * offset|
  always_comb begin
    cur_samp   = axis ? y_samp : x_samp;
    cur_centre = axis ? y_centre : x_centre;
    cur_lower  = axis ? y_span_lower : x_span_lower;
    cur_upper  = axis ? y_span_upper : x_span_upper;
    cur_off    = {1'b0, cur_samp} - {1'b0, cur_centre};
    cur_span   = ($signed(cur_off) > $signed(side_split)) ? cur_upper : cur_lower;
    off_mag    = cur_off[jcp_pkg::SPAN_W-1] ? jcp_pkg::SAMPLE_W'(-cur_off)
                                            : cur_off[jcp_pkg::SAMPLE_W-1:0];
    prod       = jcp_pkg::NUM_W'(full_scale) * jcp_pkg::NUM_W'(off_mag);
  end

  // handle a zero span, clamp the quotient magnitude and apply the sign
  always_comb begin
    if (span_zero) begin
      mag = off_nz ? full_scale : '0;
    end else if (div_q > jcp_pkg::NUM_W'(full_scale)) begin
      mag = full_scale;
    end else begin
      mag = div_q[jcp_pkg::FS_W-1:0];
    end
    pos_new = neg ? jcp_pkg::POS_W'(-{1'b0, mag}) : {1'b0, mag};
  end

  always_comb begin
    px_s = {pos_x[jcp_pkg::POS_W-1], pos_x};
    py_s = {pos_y[jcp_pkg::POS_W-1], pos_y};
    th_s = {2'b00, dir_threshold};
    if (px_s > th_s) begin
      dir_new = jcp_pkg::DIR_RIGHT;
    end else if (px_s < -th_s) begin
      dir_new = jcp_pkg::DIR_LEFT;
    end else if (py_s > th_s) begin
      dir_new = jcp_pkg::DIR_UP;
    end else if (py_s < -th_s) begin
      dir_new = jcp_pkg::DIR_DOWN;
    end else begin
      dir_new = jcp_pkg::DIR_MIDDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jcp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    case (state)
      jcp_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && in_mode == jcp_pkg::MODE_MEASURE) state_next = jcp_pkg::ST_MUL;
      end
      jcp_pkg::ST_MUL: begin
        state_next = jcp_pkg::ST_START;
      end
      jcp_pkg::ST_START: begin
        div_start  = 1'b1;
        state_next = jcp_pkg::ST_WAIT;
      end
      jcp_pkg::ST_WAIT: begin
        if (div_done) state_next = axis ? jcp_pkg::ST_DONE : jcp_pkg::ST_MUL;
      end
      jcp_pkg::ST_DONE: begin
        if (out_free) state_next = jcp_pkg::ST_IDLE;
      end
      default: state_next = jcp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis <= 1'b0;
    end else if (accept) begin
      axis <= 1'b0;
    end else if (state == jcp_pkg::ST_WAIT && div_done) begin
      axis <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_samp <= in_x;
      y_samp <= in_y;
    end
    if (state == jcp_pkg::ST_MUL) begin
      num       <= prod;
      span_mag  <= cur_span[jcp_pkg::SPAN_W-1] ? jcp_pkg::SAMPLE_W'(-cur_span)
                                               : cur_span[jcp_pkg::SAMPLE_W-1:0];
      span_zero <= (cur_span == '0);
      off_nz    <= (cur_off != '0);
      neg       <= (cur_span == '0) ? cur_off[jcp_pkg::SPAN_W-1]
                 : (cur_off[jcp_pkg::SPAN_W-1] ^ cur_span[jcp_pkg::SPAN_W-1]);
    end
    if (state == jcp_pkg::ST_WAIT && div_done) begin
      if (axis) pos_y <= pos_new;
      else      pos_x <= pos_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == jcp_pkg::ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == jcp_pkg::ST_DONE && out_free) begin
      m_tdata <= {5'b00000, dir_new, pos_y, pos_x};
    end
  end

  jcp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num),
    .divisor  (span_mag),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule
